### rtl/tlbr_pkg.sv
// Shared types and constants for the fully associative TLB with LRU or random replacement.
package tlbr_pkg;

    localparam int TLB_ENTRIES = 32;
    localparam int PAGE_BITS   = 16;
    localparam int FRAME_BITS  = 16;
    localparam int STAMP_BITS  = 32;
    localparam int SLOT_BITS   = 5;
    localparam int IDX_BITS    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    localparam int LFSR_BITS = 16;
    localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;

    localparam int RECIP_BITS = 32;
    localparam logic [RECIP_BITS-1:0] RECIP =
        RECIP_BITS'((64'd1 << RECIP_BITS) / TLB_ENTRIES);
    localparam int MOD_BITS = LFSR_BITS + IDX_BITS + 1;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_INVAL  = 2'd2,
        CMD_FLUSH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_RMOD,
        ST_EVICT
    } state_t;

    typedef struct packed {
        logic write;
        logic touch;
        logic clear;
        logic flush;
    } cell_ctl_t;

    typedef struct packed {
        logic                  valid;
        logic                  page_hit;
        logic                  frame_hit;
        logic [FRAME_BITS-1:0] frame;
    } cell_stat_t;

    typedef struct packed {
        logic                  go;
        logic [STAMP_BITS-1:0] low;
        logic [IDX_BITS-1:0]   best;
    } scan_t;

endpackage

### rtl/tlbr_cell.sv
// One TLB entry: storage, key compare and one stage of the oldest-stamp scan chain.
module tlbr_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [tlbr_pkg::IDX_BITS-1:0]  cell_idx,
    input  tlbr_pkg::cell_ctl_t            ctl,
    input  logic [tlbr_pkg::PAGE_BITS-1:0] item_page,
    input  logic [tlbr_pkg::FRAME_BITS-1:0] item_frame,
    input  logic [tlbr_pkg::STAMP_BITS-1:0] item_stamp,
    input  tlbr_pkg::scan_t                scan_in,
    output tlbr_pkg::scan_t                scan_out,
    output tlbr_pkg::cell_stat_t           stat
);
    import tlbr_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic                  go_reg;
    logic                  go_next;
    scan_t                 scan_reg;
    scan_t                 scan_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.flush || ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.write)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
        begin
            page_reg  <= item_page;
            frame_reg <= item_frame;
        end
        if (ctl.write || ctl.touch)
        begin
            stamp_reg <= item_stamp;
        end
    end

    // keep the older stamp and its index as the scan passes
    always_comb
    begin
        scan_next = scan_in;
        go_next   = scan_in.go;
        if (scan_in.go && valid_reg && (stamp_reg < scan_in.low))
        begin
            scan_next.low  = stamp_reg;
            scan_next.best = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go_reg <= 1'b0;
        end
        else
        begin
            go_reg <= go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    always_comb
    begin
        scan_out     = scan_reg;
        scan_out.go  = go_reg;
        stat.valid     = valid_reg;
        stat.page_hit  = valid_reg && (page_reg == item_page);
        stat.frame_hit = valid_reg && (frame_reg == item_frame);
        stat.frame     = frame_reg;
    end

endmodule

### rtl/tlb_lru_random_replace.sv
// Top level of the fully associative TLB: command control, victim choice and result register.
//
//   port group   dir  handshake             payload
//   input item   in   in_valid / in_ready   command, page_number, frame_number, access_time
//   result item  out  out_valid / out_ready hit, frame_out, slot, evicted
//   config       in   cfg_wr_en             cfg_wr_data (replace_policy)
//
// An item is accepted, then compared in all entries and the table updated.
// A fill into a full table first picks a victim: under random replacement by the LFSR reduction,
// and under LRU by the oldest-stamp scan walking the cell chain.
// Reset clears all valid bits and seeds the LFSR; no clearing pass is needed.
// A stalled result stays in the output register; the next item is accepted meanwhile.
module tlb_lru_random_replace (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [tlbr_pkg::PAGE_BITS-1:0]  page_number,
    input  logic [tlbr_pkg::FRAME_BITS-1:0] frame_number,
    input  logic [tlbr_pkg::STAMP_BITS-1:0] access_time,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            hit,
    output logic [tlbr_pkg::FRAME_BITS-1:0] frame_out,
    output logic [tlbr_pkg::SLOT_BITS-1:0]  slot,
    output logic                            evicted
);
    import tlbr_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic                  policy_reg;
    cmd_t                  cmd_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [STAMP_BITS-1:0] time_reg;

    logic [LFSR_BITS-1:0]  lfsr_reg;
    logic [LFSR_BITS-1:0]  lfsr_next;
    logic [LFSR_BITS-1:0]  q_reg;
    logic [LFSR_BITS+RECIP_BITS-1:0] recip_prod;
    logic [MOD_BITS-1:0]   mod_prod;
    logic [MOD_BITS-1:0]   mod_rem;
    logic [IDX_BITS-1:0]   rand_idx;

    logic [IDX_BITS-1:0]   victim_reg;
    logic [IDX_BITS-1:0]   victim_next;
    logic                  victim_load;

    logic                  out_valid_reg;
    logic                  hit_reg;
    logic [FRAME_BITS-1:0] frame_out_reg;
    logic [SLOT_BITS-1:0]  slot_reg;
    logic                  evicted_reg;
    logic                  hit_next;
    logic [FRAME_BITS-1:0] frame_out_next;
    logic [SLOT_BITS-1:0]  slot_next;
    logic                  evicted_next;
    logic                  out_load;
    logic                  out_free;

    cell_ctl_t  ctl [TLB_ENTRIES];
    cell_stat_t stat [TLB_ENTRIES];
    scan_t      chain [TLB_ENTRIES+1];

    logic                  wr_en;
    logic                  touch_en;
    logic                  clear_en;
    logic                  flush_en;
    logic [IDX_BITS-1:0]   op_idx;
    logic                  scan_start;
    logic                  lfsr_adv;

    logic                  page_found;
    logic                  frame_found;
    logic                  free_found;
    logic [IDX_BITS-1:0]   page_idx;
    logic [IDX_BITS-1:0]   frame_idx;
    logic [IDX_BITS-1:0]   free_idx;
    logic                  table_full;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            policy_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd_t'(command);
            page_reg  <= page_number;
            frame_reg <= frame_number;
            time_reg  <= access_time;
        end
    end

    // lowest index wins for every search
    always_comb
    begin
        page_found  = 1'b0;
        frame_found = 1'b0;
        free_found  = 1'b0;
        page_idx    = '0;
        frame_idx   = '0;
        free_idx    = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (stat[i].page_hit)
            begin
                page_found = 1'b1;
                page_idx   = IDX_BITS'(i);
            end
            if (stat[i].frame_hit)
            begin
                frame_found = 1'b1;
                frame_idx   = IDX_BITS'(i);
            end
            if (!stat[i].valid)
            begin
                free_found = 1'b1;
                free_idx   = IDX_BITS'(i);
            end
        end
        table_full = !free_found;
    end

    assign lfsr_next  = {lfsr_reg[0] ^ lfsr_reg[2] ^ lfsr_reg[3] ^ lfsr_reg[5],
                         lfsr_reg[LFSR_BITS-1:1]};
    assign recip_prod = (LFSR_BITS+RECIP_BITS)'(lfsr_next)
                      * (LFSR_BITS+RECIP_BITS)'(RECIP);

    always_comb
    begin
        mod_prod = MOD_BITS'(q_reg) * MOD_BITS'(TLB_ENTRIES);
        mod_rem  = MOD_BITS'(lfsr_reg) - mod_prod;
        if (mod_rem >= MOD_BITS'(TLB_ENTRIES))
        begin
            mod_rem = mod_rem - MOD_BITS'(TLB_ENTRIES);
        end
        rand_idx = mod_rem[IDX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_SEED;
        end
        else if (lfsr_adv)
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lfsr_adv)
        begin
            q_reg <= recip_prod[LFSR_BITS+RECIP_BITS-1:RECIP_BITS];
        end
        if (victim_load)
        begin
            victim_reg <= victim_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg == CMD_FILL && !page_found && table_full)
                begin
                    state_next = policy_reg ? ST_RMOD : ST_SCAN;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (chain[TLB_ENTRIES].go)
                begin
                    state_next = ST_EVICT;
                end
            end
            ST_RMOD:
            begin
                state_next = ST_EVICT;
            end
            ST_EVICT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en          = 1'b0;
        touch_en       = 1'b0;
        clear_en       = 1'b0;
        flush_en       = 1'b0;
        op_idx         = '0;
        scan_start     = 1'b0;
        lfsr_adv       = 1'b0;
        victim_load    = 1'b0;
        victim_next    = rand_idx;
        out_load       = 1'b0;
        hit_next       = 1'b0;
        frame_out_next = '0;
        slot_next      = '0;
        evicted_next   = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                if (cmd_reg == CMD_FILL && !page_found && table_full)
                begin
                    scan_start = !policy_reg;
                    lfsr_adv   = policy_reg;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    unique case (cmd_reg)
                        CMD_LOOKUP:
                        begin
                            touch_en = page_found;
                            op_idx   = page_idx;
                            if (page_found)
                            begin
                                hit_next       = 1'b1;
                                frame_out_next = stat[page_idx].frame;
                                slot_next      = SLOT_BITS'(page_idx);
                            end
                        end
                        CMD_FILL:
                        begin
                            wr_en     = 1'b1;
                            op_idx    = page_found ? page_idx : free_idx;
                            slot_next = SLOT_BITS'(op_idx);
                        end
                        CMD_INVAL:
                        begin
                            clear_en = frame_found;
                            op_idx   = frame_idx;
                            if (frame_found)
                            begin
                                hit_next       = 1'b1;
                                frame_out_next = stat[frame_idx].frame;
                                slot_next      = SLOT_BITS'(frame_idx);
                            end
                        end
                        CMD_FLUSH:
                        begin
                            flush_en = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                victim_load = chain[TLB_ENTRIES].go;
                victim_next = chain[TLB_ENTRIES].best;
            end
            ST_RMOD:
            begin
                victim_load = 1'b1;
                victim_next = rand_idx;
            end
            ST_EVICT:
            begin
                if (out_free)
                begin
                    wr_en        = 1'b1;
                    op_idx       = victim_reg;
                    out_load     = 1'b1;
                    slot_next    = SLOT_BITS'(victim_reg);
                    evicted_next = 1'b1;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            hit_reg       <= hit_next;
            frame_out_reg <= frame_out_next;
            slot_reg      <= slot_next;
            evicted_reg   <= evicted_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign frame_out = frame_out_reg;
    assign slot      = slot_reg;
    assign evicted   = evicted_reg;

    always_comb
    begin
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            ctl[i].write = wr_en && (op_idx == IDX_BITS'(i));
            ctl[i].touch = touch_en && (op_idx == IDX_BITS'(i));
            ctl[i].clear = clear_en && (op_idx == IDX_BITS'(i));
            ctl[i].flush = flush_en;
        end
    end

    // inject the scan at the head of the chain with the current time as bound
    always_comb
    begin
        chain[0].go   = scan_start;
        chain[0].low  = time_reg;
        chain[0].best = '0;
    end

    for (genvar g = 0; g < TLB_ENTRIES; g++)
    begin : g_cell
        tlbr_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_BITS'(g)),
            .ctl        (ctl[g]),
            .item_page  (page_reg),
            .item_frame (frame_reg),
            .item_stamp (time_reg),
            .scan_in    (chain[g]),
            .scan_out   (chain[g+1]),
            .stat       (stat[g])
        );
    end

endmodule

### tb/tlb_lru_random_replace_tb.sv
// Testbench for the fully associative TLB with LRU or random replacement, checked item by item.
module tlb_lru_random_replace_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbr_pkg::*;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame;
        logic [SLOT_BITS-1:0]  slot;
        logic                  evicted;
    } tlb_resp_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  cfg_wr_en    = 1'b0;
    logic                  cfg_wr_data  = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [1:0]            command      = '0;
    logic [PAGE_BITS-1:0]  page_number  = '0;
    logic [FRAME_BITS-1:0] frame_number = '0;
    logic [STAMP_BITS-1:0] access_time  = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  hit;
    logic [FRAME_BITS-1:0] frame_out;
    logic [SLOT_BITS-1:0]  slot;
    logic                  evicted;

    logic [PAGE_BITS-1:0]  ent_page  [TLB_ENTRIES];
    logic [FRAME_BITS-1:0] ent_frame [TLB_ENTRIES];
    logic [STAMP_BITS-1:0] ent_stamp [TLB_ENTRIES];
    bit                    ent_valid [TLB_ENTRIES];
    logic [LFSR_BITS-1:0]  lfsr_q   = LFSR_SEED;
    bit                    policy_q = 1'b0;

    tlb_resp_t             pending_resp [$];
    tlb_resp_t             head_resp;
    int                    fail_count = 0;
    int                    burst_left = 0;
    int                    rx_mode    = 0;
    int                    rx_left    = 0;
    int unsigned           rx_phase   = 0;
    logic [STAMP_BITS-1:0] clock_now  = '0;

    tlb_lru_random_replace dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .page_number  (page_number),
        .frame_number (frame_number),
        .access_time  (access_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .frame_out    (frame_out),
        .slot         (slot),
        .evicted      (evicted)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic tlb_resp_t tlb_apply_cmd(input cmd_t c, input logic [PAGE_BITS-1:0] pg,
                                                input logic [FRAME_BITS-1:0] fr,
                                                input logic [STAMP_BITS-1:0] t);
        tlb_resp_t             r;
        int                    at;
        logic [STAMP_BITS-1:0] low;
        logic                  fb;
        r  = '0;
        at = -1;
        case (c)
            CMD_LOOKUP:
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (at < 0 && ent_valid[i] && ent_page[i] == pg)
                        at = i;
                if (at >= 0)
                begin
                    ent_stamp[at] = t;
                    r.hit   = 1'b1;
                    r.frame = ent_frame[at];
                    r.slot  = SLOT_BITS'(at);
                end
            end
            CMD_FILL:
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (at < 0 && ent_valid[i] && ent_page[i] == pg)
                        at = i;
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (at < 0 && !ent_valid[i])
                        at = i;
                if (at < 0)
                begin
                    r.evicted = 1'b1;
                    if (policy_q)
                    begin
                        fb     = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
                        lfsr_q = {fb, lfsr_q[LFSR_BITS-1:1]};
                        at     = int'(lfsr_q) % TLB_ENTRIES;
                    end
                    else
                    begin
                        at  = 0;
                        low = t;
                        for (int i = 0; i < TLB_ENTRIES; i++)
                            if (ent_valid[i] && ent_stamp[i] < low)
                            begin
                                low = ent_stamp[i];
                                at  = i;
                            end
                    end
                end
                ent_page[at]  = pg;
                ent_frame[at] = fr;
                ent_stamp[at] = t;
                ent_valid[at] = 1'b1;
                r.slot        = SLOT_BITS'(at);
            end
            CMD_INVAL:
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                    if (at < 0 && ent_valid[i] && ent_frame[i] == fr)
                        at = i;
                if (at >= 0)
                begin
                    ent_valid[at] = 1'b0;
                    r.hit   = 1'b1;
                    r.frame = ent_frame[at];
                    r.slot  = SLOT_BITS'(at);
                end
            end
            default:
            begin
                for (int i = 0; i < TLB_ENTRIES; i++)
                    ent_valid[i] = 1'b0;
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_resp.size() == 0)
            begin
                if (fail_count < 10)
                    $display("unexpected result: hit=%0d frame=%h slot=%0d evicted=%0d",
                             hit, frame_out, slot, evicted);
                fail_count++;
            end
            else
            begin
                head_resp = pending_resp.pop_front();
                if (head_resp.hit !== hit || head_resp.frame !== frame_out ||
                    head_resp.slot !== slot || head_resp.evicted !== evicted)
                begin
                    if (fail_count < 10)
                        $display("mismatch: want hit=%0d frame=%h slot=%0d evicted=%0d, got hit=%0d frame=%h slot=%0d evicted=%0d",
                                 head_resp.hit, head_resp.frame, head_resp.slot,
                                 head_resp.evicted, hit, frame_out, slot, evicted);
                    fail_count++;
                end
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(3);
            rx_left = $urandom_range(400, 40);
        end
        else
            rx_left--;
        rx_phase++;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(1));
            2:       out_ready <= ($urandom_range(3) == 0);
            default: out_ready <= ((rx_phase % 7) >= 3);
        endcase
    end

    task automatic send_item(input cmd_t c, input logic [PAGE_BITS-1:0] pg,
                             input logic [FRAME_BITS-1:0] fr, input logic [STAMP_BITS-1:0] t);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(10, 1)) @(posedge clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(64, 16) : $urandom_range(8, 1);
        end
        in_valid     <= 1'b1;
        command      <= c;
        page_number  <= pg;
        frame_number <= fr;
        access_time  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_resp.push_back(tlb_apply_cmd(c, pg, fr, t));
        burst_left--;
    endtask

    task automatic drain_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_resp.size() != 0) @(posedge clk);
    endtask

    task automatic set_policy(input bit p);
        drain_results();
        repeat (TLB_ENTRIES + 8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        policy_q  = p;
    endtask

    task automatic test_basic_commands();
        send_item(CMD_LOOKUP, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(CMD_INVAL,  16'hFFFF, 16'h0000, 32'h0000_0001);
        send_item(CMD_FLUSH,  16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_FILL,   16'h0000, 16'h1234, 32'h0000_0000);
        send_item(CMD_FILL,   16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(CMD_FILL,   16'h00AA, 16'h1234, 32'h0000_0005);
        send_item(CMD_LOOKUP, 16'hFFFF, 16'h0000, 32'h0000_0010);
        send_item(CMD_LOOKUP, 16'h0000, 16'hFFFF, 32'h0000_0011);
        send_item(CMD_LOOKUP, 16'h5555, 16'hAAAA, 32'h8000_0000);
        send_item(CMD_INVAL,  16'h0000, 16'h1234, 32'h0000_0012);
        // rewrite in place even with slot 0 now empty
        send_item(CMD_FILL,   16'h00AA, 16'h00BB, 32'h0000_0007);
        send_item(CMD_INVAL,  16'h0000, 16'h1234, 32'h0000_0013);
        send_item(CMD_FILL,   16'h0001, 16'hFFFF, 32'h0000_0014);
        send_item(CMD_INVAL,  16'h0000, 16'hFFFF, 32'h0000_0015);
        send_item(CMD_LOOKUP, 16'h0001, 16'h0000, 32'h0000_0016);
        send_item(CMD_FLUSH,  16'h0000, 16'h0000, 32'h0000_0000);
        send_item(CMD_LOOKUP, 16'h00AA, 16'h0000, 32'h0000_0017);
        send_item(CMD_INVAL,  16'h0000, 16'h00BB, 32'h0000_0018);
    endtask

    task automatic test_lru_victim();
        set_policy(1'b0);
        send_item(CMD_FLUSH, 16'h0000, 16'h0000, 32'h0);
        for (int i = 0; i < TLB_ENTRIES; i++)
            send_item(CMD_FILL, 16'h1000 + 16'(i), 16'h2000 + 16'(i), 32'd20);
        send_item(CMD_LOOKUP, 16'h1007, 16'h0000, 32'd10);
        send_item(CMD_LOOKUP, 16'h1003, 16'h0000, 32'd10);
        send_item(CMD_FILL,   16'h3000, 16'h4000, 32'd30);
        send_item(CMD_FILL,   16'h3001, 16'h4001, 32'd0);
        send_item(CMD_FILL,   16'h3002, 16'h4002, 32'hFFFF_FFFF);
        send_item(CMD_FILL,   16'h1005, 16'h4444, 32'd40);
        send_item(CMD_INVAL,  16'h0000, 16'h2009, 32'd41);
        send_item(CMD_FILL,   16'h3003, 16'h4003, 32'd50);
        send_item(CMD_FILL,   16'h3004, 16'h4004, 32'd60);
    endtask

    task automatic test_random_victim();
        set_policy(1'b1);
        send_item(CMD_FLUSH, 16'h0000, 16'h0000, 32'h0);
        for (int i = 0; i < TLB_ENTRIES + 10; i++)
            send_item(CMD_FILL, 16'h5000 + 16'(i), 16'h6000 + 16'(i), 32'(i));
        for (int i = 0; i < 8; i++)
            send_item(CMD_LOOKUP, 16'h5000 + 16'(i * 5), 16'h0000, 32'(100 + i));
    endtask

    task automatic test_random_traffic(input int n_items, input bit pol);
        logic [PAGE_BITS-1:0]  page_pool  [64];
        logic [FRAME_BITS-1:0] frame_pool [16];
        int                    pool_n;
        int                    pick;
        cmd_t                  c;
        logic [PAGE_BITS-1:0]  pg;
        logic [FRAME_BITS-1:0] fr;
        logic [STAMP_BITS-1:0] t;
        set_policy(pol);
        pool_n = $urandom_range(64, 24);
        foreach (page_pool[i])
            page_pool[i] = 16'($urandom);
        foreach (frame_pool[i])
            frame_pool[i] = 16'($urandom);
        clock_now = ($urandom_range(3) == 0) ? 32'hFFFF_FF00 : 32'($urandom_range(1000));
        for (int k = 0; k < n_items; k++)
        begin
            if (k == n_items / 2)
                drain_results();
            pick = $urandom_range(99);
            if (pick < 45)
                c = CMD_LOOKUP;
            else if (pick < 86)
                c = CMD_FILL;
            else if (pick < 99)
                c = CMD_INVAL;
            else
                c = CMD_FLUSH;
            pg = ($urandom_range(99) < 85) ? page_pool[$urandom_range(pool_n - 1)] : 16'($urandom);
            fr = ($urandom_range(99) < 80) ? frame_pool[$urandom_range(15)] : 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                clock_now = clock_now + 32'($urandom_range(3));
                t = clock_now;
            end
            else if (pick < 95)
                t = $urandom;
            else if (pick < 97)
                t = '0;
            else if (pick < 99)
                t = '1;
            else
                t = clock_now - 32'($urandom_range(50));
            send_item(c, pg, fr, t);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_commands();
        test_lru_victim();
        test_random_victim();
        test_random_traffic(240, 1'b0);
        test_random_traffic(240, 1'b1);
        test_random_traffic(240, 1'b0);
        test_random_traffic(240, 1'b1);
        test_random_traffic(240, 1'b1);
        test_random_traffic(240, 1'b0);
        drain_results();
        repeat (TLB_ENTRIES + 8) @(posedge clk);
        fail_count += pending_resp.size();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
